/* sv/resp_reply_stream_parser_core_macros.svh */
// Assertion helpers shared by the parser RTL. They compile to nothing for synthesis.
`ifndef RESP_REPLY_STREAM_PARSER_CORE_MACROS_SVH
`define RESP_REPLY_STREAM_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RRSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rrsp: implication check failed");
// Next-cycle implication.
`define RRSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rrsp: next-cycle check failed");
`else
`define RRSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RRSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/rrsp_pkg.sv */
`default_nettype none
package rrsp_pkg;

	// Parse phases
	localparam logic [3:0] PH_HEAD      = 4'd0;
	localparam logic [3:0] PH_LINE      = 4'd1;
	localparam logic [3:0] PH_LEN_START = 4'd2;
	localparam logic [3:0] PH_LEN_DIG   = 4'd3;
	localparam logic [3:0] PH_CNT_START = 4'd4;
	localparam logic [3:0] PH_CNT_DIG   = 4'd5;
	localparam logic [3:0] PH_DATA      = 4'd6;
	localparam logic [3:0] PH_TAIL      = 4'd7;

	// Element types
	localparam logic [2:0] TY_ERROR  = 3'd0;
	localparam logic [2:0] TY_SIMPLE = 3'd1;
	localparam logic [2:0] TY_INT    = 3'd2;
	localparam logic [2:0] TY_BULK   = 3'd3;
	localparam logic [2:0] TY_NULL   = 3'd4;
	localparam logic [2:0] TY_OTHER  = 3'd5;

	// Reply status
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ERR  = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;

	// Characters
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;

	localparam logic [30:0] NUM_SAT          = 31'h7FFF_FFFF;
	localparam logic [29:0] BULK_LIMIT_RESET = 30'd33554432;

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int CNT_W      = 3;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_byte;
		logic       elem_end;
		logic [2:0] elem_type;
		logic       elem_bad;
		logic [3:0] nest_depth;
		logic       reply_done;
		logic [1:0] reply_status;
	} rrsp_result_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [2:0]  cur_type;
		logic [30:0] accum;
		logic        neg;
		logic        stopped;
		logic        held_cr;
		logic [29:0] bulk_rem;
		logic [1:0]  tail;
		logic        err_seen;
	} rrsp_state_t;

	typedef struct packed {
		logic        push;
		logic        finish;
		logic        clear;
		logic [30:0] push_count;
	} rrsp_stack_op_t;

endpackage
`default_nettype wire

/* sv/rrsp_stack.sv */
`default_nettype none
`include "resp_reply_stream_parser_core_macros.svh"
module rrsp_stack #(
	parameter int MAX_DEPTH = 8,
	localparam int DEP_W = $clog2(MAX_DEPTH + 1),
	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  rrsp_pkg::rrsp_stack_op_t op,
	output logic [DEP_W-1:0]         depth,
	output logic                     fin_done
);
	import rrsp_pkg::*;

	logic [30:0]          count_q [MAX_DEPTH];
	logic [MAX_DEPTH-1:0] is_one_q;
	logic [DEP_W-1:0]     depth_q;
	logic [MAX_DEPTH-1:0] open_lvl;
	logic                 found;
	logic [IDX_W-1:0]     k;
	logic [30:0]          cnt_k;

	// Levels whose count is one close together with the top; find the highest one that stays.
	always_comb begin
		found = 1'b0;
		k = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			open_lvl[i] = (DEP_W'(i) < depth_q) && !is_one_q[i];
			if (open_lvl[i]) begin
				found = 1'b1;
				k = IDX_W'(i);
			end
		end
	end

	assign cnt_k    = count_q[k];
	assign fin_done = !found;
	assign depth    = depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (en) begin
			if (op.clear) begin
				depth_q <= '0;
			end else if (op.push) begin
				depth_q <= depth_q + DEP_W'(1);
			end else if (op.finish) begin
				depth_q <= found ? DEP_W'(k) + DEP_W'(1) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && op.push) begin
			count_q[depth_q[IDX_W-1:0]]  <= op.push_count;
			is_one_q[depth_q[IDX_W-1:0]] <= (op.push_count == 31'd1);
		end else if (en && op.finish && found) begin
			count_q[k]  <= cnt_k - 31'd1;
			is_one_q[k] <= (cnt_k == 31'd2);
		end
	end

	`RRSP_ASSERT_IMPLY(a_push_room, clk, arst_n, en && op.push, depth_q < DEP_W'(MAX_DEPTH))
	`RRSP_ASSERT_NEXT(a_done_empties, clk, arst_n, en && op.finish && fin_done, depth_q == '0)

endmodule
`default_nettype wire

/* sv/rrsp_parse.sv */
`default_nettype none
module rrsp_parse #(
	parameter int MAX_DEPTH = 8,
	localparam int DEP_W = $clog2(MAX_DEPTH + 1)
) (
	input  rrsp_pkg::rrsp_state_t    st,
	input  wire [7:0]                data_byte,
	input  wire [29:0]               bulk_length_limit,
	input  wire [DEP_W-1:0]          stk_depth,
	input  wire                      fin_done,
	output rrsp_pkg::rrsp_state_t    st_next,
	output rrsp_pkg::rrsp_stack_op_t op,
	output rrsp_pkg::rrsp_result_t   res0,
	output rrsp_pkg::rrsp_result_t   res1,
	output logic [1:0]               res_n
);
	import rrsp_pkg::*;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SP) || (b inside {[CH_TAB:CH_CR]});
	endfunction

	// Feed one character into the decimal reader.
	function automatic rrsp_state_t num_byte(input rrsp_state_t s, input logic [7:0] b);
		rrsp_state_t r;
		logic        digit;
		logic [34:0] prod;
		r = s;
		digit = (b >= CH_0) && (b <= CH_9);
		prod = {1'b0, s.accum, 3'b000} + {3'b000, s.accum, 1'b0} + {27'd0, b - CH_0};
		if (s.phase == PH_LEN_START || s.phase == PH_CNT_START) begin
			if (is_ws(b)) begin
				return r;
			end
			r.phase = s.phase + 4'd1;
			if (b == CH_PLUS || b == CH_MINUS) begin
				r.neg = (b == CH_MINUS);
				return r;
			end
		end
		if (digit && !s.stopped) begin
			r.accum = (prod > {4'd0, NUM_SAT}) ? NUM_SAT : prod[30:0];
		end else begin
			r.stopped = 1'b1;
		end
		return r;
	endfunction

	function automatic rrsp_result_t payload_res(input logic [7:0] b, input logic [2:0] ty,
	                                             input logic [3:0] nest);
		rrsp_result_t r;
		r = '0;
		r.payload_byte = b;
		r.has_byte = 1'b1;
		r.elem_type = ty;
		r.nest_depth = nest;
		return r;
	endfunction

	function automatic rrsp_result_t end_res(input logic [2:0] ty, input logic bad,
	                                         input logic done, input logic err,
	                                         input logic at_top, input logic [3:0] nest);
		rrsp_result_t r;
		r = '0;
		r.elem_end = 1'b1;
		r.elem_type = ty;
		r.elem_bad = bad;
		r.nest_depth = nest;
		r.reply_done = done;
		if (done) begin
			r.reply_status = (bad && at_top) ? ST_FAIL : (err ? ST_ERR : ST_OK);
		end
		return r;
	endfunction

	logic [3:0]  nest;
	logic        at_top;
	logic        fin_req;
	logic [2:0]  fin_type;
	logic        fin_bad;
	logic        neg_eff;
	logic [29:0] rem_dec;
	rrsp_state_t ns_tmp;

	assign nest   = 4'(stk_depth);
	assign at_top = (stk_depth == '0);

	always_comb begin
		st_next  = st;
		op       = '0;
		res0     = '0;
		res1     = '0;
		res_n    = 2'd0;
		fin_req  = 1'b0;
		fin_type = TY_OTHER;
		fin_bad  = 1'b0;
		neg_eff  = st.neg && (st.accum != '0);
		rem_dec  = (st.bulk_rem != '0) ? st.bulk_rem - 30'd1 : st.bulk_rem;
		ns_tmp   = num_byte(st, CH_CR);
		case (st.phase)
			PH_HEAD: begin
				st_next.held_cr = 1'b0;
				st_next.accum   = '0;
				st_next.neg     = 1'b0;
				st_next.stopped = 1'b0;
				case (data_byte)
					CH_MINUS: begin
						st_next.cur_type = TY_ERROR;
						st_next.phase    = PH_LINE;
					end
					CH_PLUS: begin
						st_next.cur_type = TY_SIMPLE;
						st_next.phase    = PH_LINE;
					end
					CH_COLON: begin
						st_next.cur_type = TY_INT;
						st_next.phase    = PH_LINE;
					end
					CH_DOLLAR: begin
						st_next.cur_type = TY_BULK;
						st_next.phase    = PH_LEN_START;
					end
					CH_STAR: begin
						st_next.cur_type = TY_OTHER;
						st_next.phase    = PH_CNT_START;
					end
					default: begin
						st_next.cur_type = TY_OTHER;
						fin_req  = 1'b1;
						fin_type = TY_OTHER;
						fin_bad  = 1'b1;
					end
				endcase
			end
			PH_LINE: begin
				if (st.held_cr) begin
					if (data_byte == CH_LF) begin
						if (st.cur_type == TY_ERROR) begin
							st_next.err_seen = 1'b1;
						end
						fin_req  = 1'b1;
						fin_type = st.cur_type;
					end else begin
						// Release the held CR, then the new byte unless it is another CR.
						res0  = payload_res(CH_CR, st.cur_type, nest);
						res_n = 2'd1;
						if (data_byte != CH_CR) begin
							st_next.held_cr = 1'b0;
							res1  = payload_res(data_byte, st.cur_type, nest);
							res_n = 2'd2;
						end
					end
				end else if (data_byte == CH_CR) begin
					st_next.held_cr = 1'b1;
				end else begin
					res0  = payload_res(data_byte, st.cur_type, nest);
					res_n = 2'd1;
				end
			end
			PH_LEN_START, PH_LEN_DIG, PH_CNT_START, PH_CNT_DIG: begin
				if (st.held_cr && data_byte == CH_LF) begin
					st_next.held_cr = 1'b0;
					if (st.phase inside {PH_LEN_START, PH_LEN_DIG}) begin
						if (neg_eff && st.accum == 31'd1) begin
							fin_req  = 1'b1;
							fin_type = TY_NULL;
						end else if (neg_eff || st.accum >= {1'b0, bulk_length_limit}) begin
							fin_req  = 1'b1;
							fin_type = TY_BULK;
							fin_bad  = 1'b1;
						end else begin
							st_next.bulk_rem = st.accum[29:0];
							st_next.tail     = 2'd2;
							st_next.phase    = (st.accum[29:0] != '0) ? PH_DATA : PH_TAIL;
						end
					end else begin
						if (neg_eff) begin
							fin_req  = 1'b1;
							fin_type = TY_OTHER;
							fin_bad  = 1'b1;
						end else if (st.accum == '0) begin
							fin_req  = 1'b1;
							fin_type = TY_OTHER;
						end else if (stk_depth >= DEP_W'(MAX_DEPTH)) begin
							// Too deep: fail the whole reply.
							res0  = end_res(TY_OTHER, 1'b1, 1'b1, 1'b0, 1'b1, nest);
							res_n = 2'd1;
							op.clear         = 1'b1;
							st_next.err_seen = 1'b0;
							st_next.phase    = PH_HEAD;
						end else begin
							op.push       = 1'b1;
							op.push_count = st.accum;
							st_next.phase = PH_HEAD;
						end
					end
				end else if (st.held_cr) begin
					// A CR not ending the line is a number character.
					st_next = ns_tmp;
					if (data_byte != CH_CR) begin
						ns_tmp.held_cr = 1'b0;
						st_next = num_byte(ns_tmp, data_byte);
					end
				end else if (data_byte == CH_CR) begin
					st_next.held_cr = 1'b1;
				end else begin
					st_next = num_byte(st, data_byte);
				end
			end
			PH_DATA: begin
				res0  = payload_res(data_byte, st.cur_type, nest);
				res_n = 2'd1;
				st_next.bulk_rem = rem_dec;
				if (rem_dec == '0) begin
					st_next.tail  = 2'd2;
					st_next.phase = PH_TAIL;
				end
			end
			PH_TAIL: begin
				if (st.tail > 2'd1) begin
					st_next.tail = st.tail - 2'd1;
				end else begin
					st_next.tail = 2'd0;
					fin_req  = 1'b1;
					fin_type = TY_BULK;
				end
			end
			default: begin
				st_next.phase   = PH_HEAD;
				st_next.held_cr = 1'b0;
			end
		endcase

		if (fin_req) begin
			st_next.held_cr = 1'b0;
			st_next.phase   = PH_HEAD;
			op.finish       = 1'b1;
			res0  = end_res(fin_type, fin_bad, fin_done, st_next.err_seen, at_top, nest);
			res_n = 2'd1;
			if (fin_done) begin
				st_next.err_seen = 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/rrsp_out_fifo.sv */
`default_nettype none
`include "resp_reply_stream_parser_core_macros.svh"
module rrsp_out_fifo (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire [1:0]              push_n,
	input  rrsp_pkg::rrsp_result_t push0,
	input  rrsp_pkg::rrsp_result_t push1,
	output logic                   space_ok,
	output logic                   out_valid,
	input  wire                    out_ready,
	output rrsp_pkg::rrsp_result_t head
);
	import rrsp_pkg::*;

	rrsp_result_t     mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	// Room for the worst case of two results from one byte.
	assign space_ok  = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push1;
		end
	end

	`RRSP_ASSERT_IMPLY(a_no_overflow, clk, arst_n, push_n != 2'd0, ({1'b0, count_q} + {2'b00, push_n}) <= 4'(FIFO_DEPTH))

endmodule
`default_nettype wire

/* sv/resp_reply_stream_parser_core.sv */
// RESP2 reply parser, one raw reply byte per input transaction.
// Input channel: in_valid / in_ready with data_byte. Output channel: out_valid /
// out_ready with the result fields (payload byte, element end, type, bad flag,
// nesting depth, reply done and status). Config channel: cfg_valid / cfg_ready
// with bulk_length_limit; cfg_ready is always high and the write is meant for
// idle periods only.
// A byte accepted into the input register is parsed from there and its results
// are written into the result queue, from which they are offered; a queue without
// room for two results holds the byte in the input register.
// Throughput: one byte per cycle while the queue has room for its results. A byte
// may produce zero, one or two results (a held CR released together with the next
// line byte); the single output port passes those results one at a time.
// Results queue in a four-entry buffer; the parse stage advances only while two
// slots are free, so with out_ready low the block keeps taking bytes until the
// input register and queue fill, then drops in_ready and holds everything.
// Reset (arst_n low, asynchronous): parser back to the head phase, array stack
// empty, error flag clear, result queue empty, bulk_length_limit 33554432.
// The count stack needs no clearing pass: entries are always pushed before use.
`default_nettype none
`include "resp_reply_stream_parser_core_macros.svh"
module resp_reply_stream_parser_core #(
	parameter int MAX_DEPTH = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [7:0]  data_byte,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [29:0] bulk_length_limit,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] payload_byte,
	output logic       has_byte,
	output logic       elem_end,
	output logic [2:0] elem_type,
	output logic       elem_bad,
	output logic [3:0] nest_depth,
	output logic       reply_done,
	output logic [1:0] reply_status
);
	import rrsp_pkg::*;

	localparam int DEP_W = $clog2(MAX_DEPTH + 1);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             fire;
	logic             space_ok;
	logic [29:0]      limit_q;
	rrsp_state_t      st_q;
	rrsp_state_t      st_next;
	rrsp_stack_op_t   op;
	rrsp_result_t     res0;
	rrsp_result_t     res1;
	rrsp_result_t     head;
	logic [1:0]       res_n;
	logic [DEP_W-1:0] stk_depth;
	logic             fin_done;

	// Parse the held byte once the queue can take both of its possible results.
	assign fire      = valid_s1 && space_ok;
	assign in_ready  = !valid_s1 || fire;
	assign cfg_ready = 1'b1;

	// Config register: bulk length at or above this value marks the element bad.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= BULK_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= bulk_length_limit;
		end
	end

	// Input register: take a new transaction whenever the held one moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	// Parser state advances only when the held byte is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_HEAD, default: '0};
		end else if (fire) begin
			st_q <= st_next;
		end
	end

	rrsp_parse #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_parse (
		.st               (st_q),
		.data_byte        (byte_s1),
		.bulk_length_limit(limit_q),
		.stk_depth        (stk_depth),
		.fin_done         (fin_done),
		.st_next          (st_next),
		.op               (op),
		.res0             (res0),
		.res1             (res1),
		.res_n            (res_n)
	);

	rrsp_stack #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (fire),
		.op      (op),
		.depth   (stk_depth),
		.fin_done(fin_done)
	);

	rrsp_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (fire ? res_n : 2'd0),
		.push0    (res0),
		.push1    (res1),
		.space_ok (space_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign payload_byte = head.payload_byte;
	assign has_byte     = head.has_byte;
	assign elem_end     = head.elem_end;
	assign elem_type    = head.elem_type;
	assign elem_bad     = head.elem_bad;
	assign nest_depth   = head.nest_depth;
	assign reply_done   = head.reply_done;
	assign reply_status = head.reply_status;

	`RRSP_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !fire, valid_s1 && $stable(byte_s1))

endmodule
`default_nettype wire

/* bench/resp_reply_stream_parser_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the RESP2 reply parser.
// One process offers bytes on the input channel, another takes results on the
// output channel with its own random stalls, and a monitor on the clock edge
// runs every accepted input transaction through a behavioural parser written
// here. The monitor queues what that parser emits and compares each accepted
// output transaction, field by field, with the oldest queued result.
module resp_reply_stream_parser_core_tb;
	import rrsp_pkg::*;

	localparam int NEST_MAX        = 8;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int DRAIN_CYCLES    = 10;
	localparam int HOLD_AT         = 250;
	localparam int HOLD_CYCLES     = 300;
	localparam int CYCLE_LIMIT     = 300000;

	typedef struct {
		logic [7:0]   b;
		logic         typed;
		rrsp_result_t res;
	} dir_row_t;

	// Drive every input to a known value from time zero.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        cfg_valid = 1'b0;
	logic [29:0] cfg_limit = BULK_LIMIT_RESET;
	logic        out_ready = 1'b0;

	logic        in_ready;
	logic        cfg_ready;
	logic        out_valid;
	logic [7:0]  payload_byte;
	logic        has_byte;
	logic        elem_end;
	logic [2:0]  elem_type;
	logic        elem_bad;
	logic [3:0]  nest_depth;
	logic        reply_done;
	logic [1:0]  reply_status;

	// Hand-typed expectation travelling with the byte on offer.
	logic         drv_typed = 1'b0;
	rrsp_result_t drv_res   = '0;

	// Behavioural parser state, starting at its reset values.
	logic [3:0]  prs_phase  = PH_HEAD;
	logic [2:0]  prs_type   = TY_ERROR;
	logic [31:0] num_val    = '0;
	logic        num_neg    = 1'b0;
	logic        num_stop   = 1'b0;
	logic        cr_pending = 1'b0;
	logic [29:0] bulk_left  = '0;
	logic [1:0]  tail_left  = '0;
	int          arr_depth  = 0;
	logic [30:0] arr_count [NEST_MAX];
	logic        err_seen   = 1'b0;
	logic [29:0] len_limit  = BULK_LIMIT_RESET;

	rrsp_result_t pending_res [$];
	logic [7:0]   pend_q [$];
	dir_row_t     dir_tab [$];
	logic [29:0]  gen_limit = BULK_LIMIT_RESET;
	int           n_sent    = 0;
	int           n_err     = 0;
	int           n_cycles  = 0;
	int           n_before;

	resp_reply_stream_parser_core #(
		.MAX_DEPTH(NEST_MAX)
	) i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.data_byte         (data_byte),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.bulk_length_limit (cfg_limit),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.payload_byte      (payload_byte),
		.has_byte          (has_byte),
		.elem_end          (elem_end),
		.elem_type         (elem_type),
		.elem_bad          (elem_bad),
		.nest_depth        (nest_depth),
		.reply_done        (reply_done),
		.reply_status      (reply_status)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Queue helpers
	// ---------------------------------------------------------------------
	function automatic void queue_result(input rrsp_result_t r);
		pending_res.insert(pending_res.size(), r);
	endfunction

	function automatic void queue_byte(input logic [7:0] b);
		pend_q.insert(pend_q.size(), b);
	endfunction

	function automatic void add_row(input logic [7:0] b, input logic typed,
			input rrsp_result_t res);
		dir_row_t row;
		row = '{b, typed, res};
		dir_tab.insert(dir_tab.size(), row);
	endfunction

	// ---------------------------------------------------------------------
	// Behavioural parser
	// ---------------------------------------------------------------------
	function automatic rrsp_result_t mk_result(input logic [7:0] pb, input logic hb,
			input logic ee, input logic [2:0] ty, input logic bad, input logic [3:0] dp,
			input logic dn, input logic [1:0] st);
		rrsp_result_t r;
		r.payload_byte = pb;
		r.has_byte     = hb;
		r.elem_end     = ee;
		r.elem_type    = ty;
		r.elem_bad     = bad;
		r.nest_depth   = dp;
		r.reply_done   = dn;
		r.reply_status = st;
		return r;
	endfunction

	function automatic void emit_content(input logic [7:0] b);
		queue_result(mk_result(b, 1'b1, 1'b0, prs_type, 1'b0, arr_depth[3:0],
			1'b0, ST_OK));
	endfunction

	// Drop the stack and the error flag; look for a fresh head byte.
	function automatic void close_reply();
		arr_depth  = 0;
		err_seen   = 1'b0;
		prs_phase  = PH_HEAD;
	endfunction

	// Close one element, then count it off every array it completes on the way up.
	function automatic void finish_elem(input logic [2:0] ty, input logic bad);
		logic [3:0] depth;
		logic       done;
		logic [1:0] st;
		int         top;
		depth      = arr_depth[3:0];
		done       = (arr_depth == 0);
		st         = ST_OK;
		cr_pending = 1'b0;
		prs_phase  = PH_HEAD;
		while (!done) begin
			top = arr_depth - 1;
			if (arr_count[top] > 0)
				arr_count[top] = arr_count[top] - 31'd1;
			if (arr_count[top] != 0)
				break;
			arr_depth--;
			if (arr_depth == 0)
				done = 1'b1;
		end
		if (done)
			st = (bad && depth == 0) ? ST_FAIL : (err_seen ? ST_ERR : ST_OK);
		queue_result(mk_result(8'h00, 1'b0, 1'b1, ty, bad, depth, done, st));
		if (done)
			close_reply();
	endfunction

	// Fold one character into a length or count, atoi style, saturating.
	function automatic void number_char(input logic [7:0] b);
		logic [31:0] d;
		d = {24'd0, b} - {24'd0, CH_0};
		if (prs_phase == PH_LEN_START || prs_phase == PH_CNT_START) begin
			if (b == CH_SP || (b >= CH_TAB && b <= CH_CR))
				return;
			prs_phase = prs_phase + 4'd1;
			if (b == CH_PLUS || b == CH_MINUS) begin
				num_neg = (b == CH_MINUS);
				return;
			end
		end
		if (b >= CH_0 && b <= CH_9 && !num_stop) begin
			if (num_val > (32'(NUM_SAT) - d) / 32'd10)
				num_val = 32'(NUM_SAT);
			else
				num_val = num_val * 32'd10 + d;
		end else begin
			num_stop = 1'b1;
		end
	endfunction

	// Advance the parser by one accepted byte and queue whatever it emits.
	function automatic void parse_byte(input logic [7:0] b);
		logic neg;
		case (prs_phase)
			PH_HEAD: begin
				cr_pending = 1'b0;
				num_val    = '0;
				num_neg    = 1'b0;
				num_stop   = 1'b0;
				case (b)
					CH_MINUS:  begin prs_type = TY_ERROR;  prs_phase = PH_LINE;      end
					CH_PLUS:   begin prs_type = TY_SIMPLE; prs_phase = PH_LINE;      end
					CH_COLON:  begin prs_type = TY_INT;    prs_phase = PH_LINE;      end
					CH_DOLLAR: begin prs_type = TY_BULK;   prs_phase = PH_LEN_START; end
					CH_STAR:   begin prs_type = TY_OTHER;  prs_phase = PH_CNT_START; end
					default: begin
						prs_type = TY_OTHER;
						finish_elem(TY_OTHER, 1'b1);
					end
				endcase
			end
			PH_LINE: begin
				if (cr_pending) begin
					if (b == CH_LF) begin
						if (prs_type == TY_ERROR)
							err_seen = 1'b1;
						finish_elem(prs_type, 1'b0);
					end else begin
						// The held CR was content after all; release it.
						emit_content(CH_CR);
						if (b != CH_CR) begin
							cr_pending = 1'b0;
							emit_content(b);
						end
					end
				end else if (b == CH_CR) begin
					cr_pending = 1'b1;
				end else begin
					emit_content(b);
				end
			end
			PH_LEN_START, PH_LEN_DIG, PH_CNT_START, PH_CNT_DIG: begin
				if (cr_pending && b == CH_LF) begin
					neg        = num_neg && num_val != 0;
					cr_pending = 1'b0;
					if (prs_phase == PH_LEN_START || prs_phase == PH_LEN_DIG) begin
						if (neg && num_val == 32'd1) begin
							finish_elem(TY_NULL, 1'b0);
						end else if (neg || num_val >= {2'b00, len_limit}) begin
							finish_elem(TY_BULK, 1'b1);
						end else begin
							bulk_left = num_val[29:0];
							tail_left = 2'd2;
							prs_phase = (bulk_left != 0) ? PH_DATA : PH_TAIL;
						end
					end else if (neg) begin
						finish_elem(TY_OTHER, 1'b1);
					end else if (num_val == 0) begin
						finish_elem(TY_OTHER, 1'b0);
					end else if (arr_depth >= NEST_MAX) begin
						// No room for another level: the whole reply fails.
						queue_result(mk_result(8'h00, 1'b0, 1'b1, TY_OTHER, 1'b1,
							arr_depth[3:0], 1'b1, ST_FAIL));
						close_reply();
					end else begin
						arr_count[arr_depth] = num_val[30:0];
						arr_depth++;
						prs_phase = PH_HEAD;
					end
				end else if (cr_pending) begin
					number_char(CH_CR);
					if (b != CH_CR) begin
						cr_pending = 1'b0;
						number_char(b);
					end
				end else if (b == CH_CR) begin
					cr_pending = 1'b1;
				end else begin
					number_char(b);
				end
			end
			PH_DATA: begin
				emit_content(b);
				if (bulk_left > 0)
					bulk_left = bulk_left - 30'd1;
				if (bulk_left == 0) begin
					tail_left = 2'd2;
					prs_phase = PH_TAIL;
				end
			end
			PH_TAIL: begin
				// Skip the two trailer bytes without looking at them.
				if (tail_left > 2'd1) begin
					tail_left = tail_left - 2'd1;
				end else begin
					tail_left = 2'd0;
					finish_elem(TY_BULK, 1'b0);
				end
			end
			default: begin
				prs_phase  = PH_HEAD;
				cr_pending = 1'b0;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------
	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			n_err++;
		end
	endtask

	task automatic check_result(input rrsp_result_t got);
		rrsp_result_t want;
		if (pending_res.size() == 0) begin
			$display("%0t unexpected result: expected none, actual %h", $time, got);
			n_err++;
			return;
		end
		want = pending_res.pop_front();
		check_field("payload_byte", want.payload_byte, got.payload_byte);
		check_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
		check_field("elem_end", 8'(want.elem_end), 8'(got.elem_end));
		check_field("elem_type", 8'(want.elem_type), 8'(got.elem_type));
		check_field("elem_bad", 8'(want.elem_bad), 8'(got.elem_bad));
		check_field("nest_depth", 8'(want.nest_depth), 8'(got.nest_depth));
		check_field("reply_done", 8'(want.reply_done), 8'(got.reply_done));
		check_field("reply_status", 8'(want.reply_status), 8'(got.reply_status));
	endtask

	// Sample both channels and the config port on every edge. Check the output
	// first; a result can never stem from a byte taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_result(mk_result(payload_byte, has_byte, elem_end, elem_type, elem_bad,
					nest_depth, reply_done, reply_status));
			if (in_valid && in_ready) begin
				n_before = pending_res.size();
				parse_byte(data_byte);
				// Typed rows replace whatever the parser queued for this byte.
				if (drv_typed) begin
					while (pending_res.size() > n_before)
						pending_res.delete(pending_res.size() - 1);
					queue_result(drv_res);
				end
			end
			if (cfg_valid && cfg_ready)
				len_limit = cfg_limit;
		end
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("resp_reply_stream_parser_core_tb: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus generation
	// ---------------------------------------------------------------------
	// Render a decimal number line with optional padding, sign and junk.
	function automatic void put_number(input longint v);
		string s;
		int    i;
		logic [7:0] ws;
		repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
			case ($urandom_range(0, 4))
				0: ws = CH_SP;
				1: ws = CH_TAB;
				2: ws = 8'h0B;
				3: ws = 8'h0C;
				default: ws = CH_CR;
			endcase
			queue_byte(ws);
		end
		if (v < 0)
			queue_byte(CH_MINUS);
		else if (v == 0 && $urandom_range(0, 5) == 0)
			queue_byte(CH_MINUS);
		else if ($urandom_range(0, 7) == 0)
			queue_byte(CH_PLUS);
		s = $sformatf("%0d", (v < 0) ? -v : v);
		if (!(v == 0 && $urandom_range(0, 3) == 0)) begin
			for (i = 0; i < s.len(); i++)
				queue_byte(s[i]);
		end
		// Trailing junk is ignored once the digits stop, a lone CR included.
		case ($urandom_range(0, 11))
			0: queue_byte(8'h78);
			1: queue_byte(CH_SP);
			2: begin queue_byte(CH_CR); queue_byte(8'h7A); end
			default: ;
		endcase
		queue_byte(CH_CR);
		queue_byte(CH_LF);
	endfunction

	// Head byte, short content with the odd CR or LF, then CR LF.
	function automatic void put_line(input logic [7:0] head);
		int         n;
		logic [7:0] c;
		logic [7:0] prev;
		queue_byte(head);
		prev = 8'h00;
		n = $urandom_range(0, 5);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: c = CH_CR;
				1: c = CH_LF;
				2, 3: c = 8'($urandom_range(0, 255));
				default: begin
					if (head == CH_COLON)
						c = CH_0 + 8'($urandom_range(0, 9));
					else
						c = 8'($urandom_range(8'h20, 8'h7E));
				end
			endcase
			// Keep CR LF out of the content so the line does not end early.
			if (c == CH_LF && prev == CH_CR)
				c = CH_SP;
			queue_byte(c);
			prev = c;
		end
		queue_byte(CH_CR);
		queue_byte(CH_LF);
	endfunction

	function automatic void put_bulk();
		longint len;
		int     r;
		r = $urandom_range(0, 99);
		queue_byte(CH_DOLLAR);
		if (r < 10) begin
			put_number(-1);
		end else if (r < 20) begin
			case ($urandom_range(0, 2))
				0: put_number(-2 - longint'($urandom_range(0, 100)));
				1: put_number(longint'(gen_limit) + longint'($urandom_range(0, 5)));
				default: put_number(64'd99999999999);
			endcase
		end else begin
			len = $urandom_range(0, 8);
			put_number(len);
			if (len < longint'(gen_limit)) begin
				repeat (len)
					queue_byte(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 6) != 0) begin
					queue_byte(CH_CR);
					queue_byte(CH_LF);
				end else begin
					queue_byte(8'($urandom_range(0, 255)));
					queue_byte(8'($urandom_range(0, 255)));
				end
			end
		end
	endfunction

	// Build one well-formed reply. Walk the array tree with an explicit stack
	// of outstanding element counts.
	function automatic void gen_reply();
		int         need [0:15];
		int         lvl;
		int         r;
		int         c;
		logic [7:0] hb;
		if ($urandom_range(0, 24) == 0) begin
			// Chain of single-element arrays around the stack limit.
			repeat ($urandom_range(NEST_MAX - 1, NEST_MAX + 1)) begin
				queue_byte(CH_STAR);
				put_number(1);
			end
			put_line(CH_PLUS);
			return;
		end
		lvl     = 0;
		need[0] = 1;
		while (lvl >= 0) begin
			if (need[lvl] == 0) begin
				lvl--;
				continue;
			end
			need[lvl]--;
			r = $urandom_range(0, 99);
			if (r >= 90 && lvl < 2) begin
				c = $urandom_range(1, 3);
				queue_byte(CH_STAR);
				put_number(c);
				lvl++;
				need[lvl] = c;
			end else if (r < 15) begin
				put_line(CH_MINUS);
			end else if (r < 30) begin
				put_line(CH_PLUS);
			end else if (r < 42) begin
				put_line(CH_COLON);
			end else if (r < 75) begin
				put_bulk();
			end else if (r < 80) begin
				hb = 8'($urandom_range(0, 255));
				if (hb == CH_MINUS || hb == CH_PLUS || hb == CH_COLON || hb == CH_DOLLAR ||
						hb == CH_STAR)
					hb = 8'h00;
				queue_byte(hb);
			end else if (r < 85) begin
				queue_byte(CH_STAR);
				put_number(0);
			end else if (r < 90) begin
				queue_byte(CH_STAR);
				put_number(-1 - longint'($urandom_range(0, 9)));
			end else begin
				put_bulk();
			end
		end
	endfunction

	// ---------------------------------------------------------------------
	// Channel drivers
	// ---------------------------------------------------------------------
	// Offer one byte; hold it until the transaction completes.
	task automatic send_byte(input logic [7:0] b, input logic typed, input rrsp_result_t res);
		int gap;
		gap = ((n_sent % 160) < 40) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		drv_typed <= typed;
		drv_res   <= res;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	// Stop offering, drain every queued result, then let the pipe go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [29:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_limit <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gen_limit = v;
	endtask

	// Take results with random stalls, a calm stretch now and then, and one long
	// hold-off so that the block backs up and stalls its input.
	initial begin : drain_results
		int stall;
		int n_taken;
		n_taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (n_taken == HOLD_AT)
				stall = HOLD_CYCLES;
			else if ((n_taken % 128) < 32)
				stall = 0;
			else
				stall = $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			n_taken++;
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin : main_seq
		int          i;
		int          r;
		int          k;
		int          target;
		logic [29:0] lim;

		// Hand-typed rows carry the one result the byte must give; the rest are
		// left to the behavioural parser.
		add_row(8'h00, 1'b1,
			mk_result(8'h00, 1'b0, 1'b1, TY_OTHER, 1'b1, 4'd0, 1'b1, ST_FAIL));
		add_row(8'hFF, 1'b1,
			mk_result(8'h00, 1'b0, 1'b1, TY_OTHER, 1'b1, 4'd0, 1'b1, ST_FAIL));
		// Error line with a doubled CR and a held CR released with a byte.
		add_row(CH_MINUS, 1'b0, '0);
		add_row(8'h45, 1'b0, '0);
		add_row(CH_CR, 1'b0, '0);
		add_row(CH_CR, 1'b0, '0);
		add_row(8'h78, 1'b0, '0);
		add_row(CH_CR, 1'b0, '0);
		add_row(CH_LF, 1'b1,
			mk_result(8'h00, 1'b0, 1'b1, TY_ERROR, 1'b0, 4'd0, 1'b1, ST_ERR));
		// Null bulk string.
		add_row(CH_DOLLAR, 1'b0, '0);
		add_row(CH_MINUS, 1'b0, '0);
		add_row(8'h31, 1'b0, '0);
		add_row(CH_CR, 1'b0, '0);
		add_row(CH_LF, 1'b1,
			mk_result(8'h00, 1'b0, 1'b1, TY_NULL, 1'b0, 4'd0, 1'b1, ST_OK));
		// Empty array.
		add_row(CH_STAR, 1'b0, '0);
		add_row(CH_0, 1'b0, '0);
		add_row(CH_CR, 1'b0, '0);
		add_row(CH_LF, 1'b1,
			mk_result(8'h00, 1'b0, 1'b1, TY_OTHER, 1'b0, 4'd0, 1'b1, ST_OK));
		// Negative array count at top level.
		add_row(CH_STAR, 1'b0, '0);
		add_row(CH_MINUS, 1'b0, '0);
		add_row(8'h32, 1'b0, '0);
		add_row(CH_CR, 1'b0, '0);
		add_row(CH_LF, 1'b1,
			mk_result(8'h00, 1'b0, 1'b1, TY_OTHER, 1'b1, 4'd0, 1'b1, ST_FAIL));
		// Integer line holding only a stray LF.
		add_row(CH_COLON, 1'b0, '0);
		add_row(CH_LF, 1'b0, '0);
		add_row(CH_CR, 1'b0, '0);
		add_row(CH_LF, 1'b1,
			mk_result(8'h00, 1'b0, 1'b1, TY_INT, 1'b0, 4'd0, 1'b1, ST_OK));

		// Hold reset once, then release it.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < dir_tab.size(); i++)
			send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].res);

		// Random replies under a series of limits, extremes included.
		for (k = 0; k < 6; k++) begin
			case (k)
				1: lim = 30'd1;
				2: lim = 30'd536870912;
				3: lim = 30'h1FFF_FFFF;
				4: lim = 30'($urandom_range(2, 9));
				5: lim = 30'($urandom_range(1, 536870912));
				default: lim = BULK_LIMIT_RESET;
			endcase
			if (k > 0)
				write_limit(lim);
			target = n_sent + ITEMS_PER_PHASE;
			while (n_sent < target) begin
				pend_q.delete();
				gen_reply();
				r = $urandom_range(0, 99);
				if (r < 7) begin
					// Plain noise instead of a reply.
					pend_q.delete();
					repeat ($urandom_range(1, 6))
						queue_byte(8'($urandom_range(0, 255)));
				end else if (r < 11) begin
					// Cut the reply short.
					i = $urandom_range(1, pend_q.size());
					while (pend_q.size() > i)
						pend_q.delete(pend_q.size() - 1);
				end else if (r < 15) begin
					// Corrupt one byte.
					pend_q[$urandom_range(0, pend_q.size() - 1)] = 8'($urandom_range(0, 255));
				end
				while (pend_q.size() != 0)
					send_byte(pend_q.pop_front(), 1'b0, '0);
			end
		end

		settle();
		if (n_err == 0)
			$display("resp_reply_stream_parser_core_tb: clean");
		else
			$display("resp_reply_stream_parser_core_tb: errors");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/rrsp_pkg.sv
sv/rrsp_stack.sv
sv/rrsp_parse.sv
sv/rrsp_out_fifo.sv
sv/resp_reply_stream_parser_core.sv
bench/resp_reply_stream_parser_core_tb.sv
